/* hw/rtl/rrsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rrsa_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GROUP  = 8;
  localparam int STEPS  = (SLOTS + GROUP - 1) / GROUP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CFG_AW = 3;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  // register index, taken from paddr[2]
  localparam logic REG_STUB_BASE = 1'b0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSTALL = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_IGNORE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RES_ZERO   = 3'd0,
    RES_BAD    = 3'd1,
    RES_FULL   = 3'd2,
    RES_GIVEN  = 3'd3,
    RES_LOOKUP = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] handler_word;
    logic [31:0] argument_word;
    logic [31:0] stub_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] given_address;
    logic [31:0] found_handler;
    logic [31:0] found_argument;
    logic        slot_in_use;
  } out_word_t;

  typedef struct packed {
    logic     accept;
    logic     search;
    logic     alloc;
    logic     clr_occ;
    logic     load_res;
    res_sel_t res_sel;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic addr_ok;
    logic found;
    logic last_step;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    if (x == LAST_IDX) begin
      return '0;
    end
    return x + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rrsa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                           wdata,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/rrsa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rrsa_pkg::dp_stat_t stat,
  output rrsa_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_sel  = rrsa_pkg::RES_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          rrsa_pkg::CMD_INSTALL: begin
            cmd.search = 1'b1;
            if (stat.found) begin
              cmd.alloc    = 1'b1;
              cmd.load_res = 1'b1;
              cmd.res_sel  = rrsa_pkg::RES_GIVEN;
              state_nxt    = S_IDLE;
            end else if (stat.last_step) begin
              cmd.load_res = 1'b1;
              cmd.res_sel  = rrsa_pkg::RES_FULL;
              state_nxt    = S_IDLE;
            end
          end
          rrsa_pkg::CMD_REMOVE: begin
            cmd.load_res = 1'b1;
            state_nxt    = S_IDLE;
            if (stat.addr_ok) begin
              cmd.clr_occ = 1'b1;
            end else begin
              cmd.res_sel = rrsa_pkg::RES_BAD;
            end
          end
          rrsa_pkg::CMD_LOOKUP: begin
            if (stat.addr_ok) begin
              state_nxt = S_READ;
            end else begin
              cmd.load_res = 1'b1;
              cmd.res_sel  = rrsa_pkg::RES_BAD;
              state_nxt    = S_IDLE;
            end
          end
          rrsa_pkg::CMD_IGNORE: begin
            cmd.load_res = 1'b1;
            state_nxt    = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // RAM word is out now
        cmd.load_res = 1'b1;
        cmd.res_sel  = rrsa_pkg::RES_LOOKUP;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_nxt == S_IDLE) |-> cmd.load_res)
    else $error("item finished without a result");

  a_alloc_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> (cmd.search && stat.found && stat.cmd == rrsa_pkg::CMD_INSTALL))
    else $error("slot taken outside a successful search");

  a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ($past(state_r) == S_EXEC && stat.cmd == rrsa_pkg::CMD_LOOKUP))
    else $error("read state entered without a lookup");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rrsa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module rrsa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rrsa_pkg::in_word_t            in_word,
  output rrsa_pkg::out_word_t                out_word,
  output logic                               out_strobe,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrsa_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire rrsa_pkg::ctl_cmd_t            cmd,
  output rrsa_pkg::dp_stat_t                 stat
);

  rrsa_pkg::in_word_t            in_r;
  rrsa_pkg::out_word_t           out_r;
  rrsa_pkg::out_word_t           res_nxt;
  logic                          strobe_r;
  logic [31:0]                   base_r;
  logic [rrsa_pkg::SLOTS-1:0]    occ_r;
  logic [rrsa_pkg::IDX_W-1:0]    last_r;
  logic [rrsa_pkg::IDX_W-1:0]    ptr_r;
  logic [rrsa_pkg::STEP_W-1:0]   step_r;
  logic [rrsa_pkg::IDX_W-1:0]    cand [rrsa_pkg::GROUP];
  logic [rrsa_pkg::IDX_W-1:0]    sel_idx;
  logic                          found;
  logic [31:0]                   off;
  logic                          addr_ok;
  logic [rrsa_pkg::IDX_W-1:0]    dec_idx;
  logic [31:0]                   given;
  logic [rrsa_pkg::IDX_W-1:0]    ram_addr;
  logic [63:0]                   ram_rdata;
  logic                          cfg_wr;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rrsa_pkg::REG_STUB_BASE);
  assign prdata = (paddr[2] == rrsa_pkg::REG_STUB_BASE) ? base_r : 32'd0;

  // address decode
  assign off     = in_r.stub_address - base_r;
  assign addr_ok = (off[1:0] == 2'b00) && (off[31:2] < 30'(rrsa_pkg::SLOTS));
  assign dec_idx = off[rrsa_pkg::IDX_W+1:2];

  // candidates of this scan step, in round-robin order
  always_comb begin
    cand[0] = rrsa_pkg::wrap_inc(ptr_r);
    for (int k = 1; k < rrsa_pkg::GROUP; k++) begin
      cand[k] = rrsa_pkg::wrap_inc(cand[k-1]);
    end
  end

  // first free candidate wins
  always_comb begin
    found   = 1'b0;
    sel_idx = cand[0];
    for (int k = rrsa_pkg::GROUP - 1; k >= 0; k--) begin
      if (!occ_r[cand[k]]) begin
        found   = 1'b1;
        sel_idx = cand[k];
      end
    end
  end

  assign given = base_r + {{(30 - rrsa_pkg::IDX_W){1'b0}}, sel_idx, 2'b00};

  assign stat.cmd       = rrsa_pkg::cmd_t'(in_r.cmd);
  assign stat.addr_ok   = addr_ok;
  assign stat.found     = found;
  assign stat.last_step = (step_r == rrsa_pkg::LAST_STEP);

  assign ram_addr = cmd.alloc ? sel_idx : dec_idx;

  rrsa_ram #(
    .WIDTH (64),
    .DEPTH (rrsa_pkg::SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.alloc),
    .addr  (ram_addr),
    .wdata ({in_r.handler_word, in_r.argument_word}),
    .rdata (ram_rdata)
  );

  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_sel)
      rrsa_pkg::RES_ZERO: begin
        res_nxt.status = rrsa_pkg::ST_OK;
      end
      rrsa_pkg::RES_BAD: begin
        res_nxt.status = rrsa_pkg::ST_BADADDR;
      end
      rrsa_pkg::RES_FULL: begin
        res_nxt.status = rrsa_pkg::ST_FULL;
      end
      rrsa_pkg::RES_GIVEN: begin
        res_nxt.status        = rrsa_pkg::ST_OK;
        res_nxt.given_address = given;
      end
      rrsa_pkg::RES_LOOKUP: begin
        res_nxt.status         = rrsa_pkg::ST_OK;
        res_nxt.found_handler  = ram_rdata[63:32];
        res_nxt.found_argument = ram_rdata[31:0];
        res_nxt.slot_in_use    = occ_r[dec_idx];
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      occ_r    <= '0;
      last_r   <= rrsa_pkg::LAST_IDX;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.load_res;
      if (cfg_wr) begin
        base_r <= pwdata;
      end
      if (cmd.alloc) begin
        occ_r[sel_idx] <= 1'b1;
        last_r         <= sel_idx;
      end
      if (cmd.clr_occ) begin
        occ_r[dec_idx] <= 1'b0;
      end
    end
  end

  // payload and scan position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r   <= in_word;
      ptr_r  <= last_r;
      step_r <= '0;
    end else if (cmd.search && !found) begin
      // advance to the next group
      ptr_r  <= cand[rrsa_pkg::GROUP-1];
      step_r <= step_r + 1'b1;
    end
    if (cmd.load_res) begin
      out_r <= res_nxt;
    end
  end

  assign out_word   = out_r;
  assign out_strobe = strobe_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("two results in consecutive cycles");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !occ_r[sel_idx])
    else $error("allocated a slot already in use");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> (occ_r[$past(sel_idx)] && last_r == $past(sel_idx)))
    else $error("allocated slot not marked");
`endif

endmodule

`default_nettype wire

/* hw/rtl/round_robin_slot_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 word
// in        in         start & !busy             in_word  (rrsa_pkg::in_word_t)
// out       out        out_strobe, one cycle     out_word (rrsa_pkg::out_word_t)
// cfg       in         APB, psel&penable&pwrite  pwdata / prdata, reg 0 stub_base
//
// Install scans in 8-slot steps after start, n of them (1 to ceil(SLOTS/8), 8 at 64
// slots), until a free slot turns up or the last step is done; remove ends in the exec
// state; a valid lookup adds a read state (registered RAM read). out_strobe rises
// the cycle after the result word is loaded, while busy stays high until that load;
// the next start is taken then. Reset clears the in-use bits, last slot and stub_base
// at once; stored words are undefined until installed. The receiver cannot stall.

module round_robin_slot_allocator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rrsa_pkg::in_word_t          in_word,
  output logic                             out_strobe,
  output rrsa_pkg::out_word_t              out_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrsa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  rrsa_pkg::ctl_cmd_t ctl_cmd;
  rrsa_pkg::dp_stat_t dp_stat;

  rrsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctl_cmd)
  );

  rrsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .out_word   (out_word),
    .out_strobe (out_strobe),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cmd        (ctl_cmd),
    .stat       (dp_stat)
  );

endmodule

`default_nettype wire
